@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/osse_pkg.sv @@
// ---------------------------------------------------------------------------
// osse_pkg
// Types and constants shared by the ordered set engine and its cells.
// ---------------------------------------------------------------------------
package osse_pkg;

	localparam int KEY_W         = 31;
	localparam int OP_W          = 3;
	localparam int OSSE_CAPACITY = 64;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_EXISTS = 3'd2,
		OP_NEXT   = 3'd3,
		OP_PREV   = 3'd4
	} osse_op_t;

	typedef struct packed {
		logic ins;
		logic del;
	} osse_cmd_t;

	typedef struct packed {
		logic occ;
		logic lt;
		logic eq;
	} osse_cell_st_t;

endpackage

@@ hdl/osse_cell.sv @@
// ---------------------------------------------------------------------------
// osse_cell
// One slot of the sorted key row: compares its key with the query and
// shifts towards or away from its neighbours on insert and delete.
// ---------------------------------------------------------------------------
module osse_cell import osse_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  osse_cmd_t               cmd,
	input  logic signed [KEY_W-1:0] query,
	input  logic                    left_occ,
	input  logic                    left_lt,
	input  logic signed [KEY_W-1:0] left_key,
	input  logic                    right_occ,
	input  logic signed [KEY_W-1:0] right_key,
	output logic signed [KEY_W-1:0] key_q,
	output osse_cell_st_t           st
);

	logic occ_q;

	assign st.occ = occ_q;
	assign st.lt  = occ_q && (key_q < query);
	assign st.eq  = occ_q && (key_q == query);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.ins && !st.lt) begin
			occ_q <= left_occ;
		end else if (cmd.del && !st.lt) begin
			occ_q <= right_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && !st.lt) begin
			key_q <= left_lt ? query : left_key;
		end else if (cmd.del && !st.lt) begin
			key_q <= right_key;
		end
	end

endmodule

@@ hdl/ordered_set_successor_engine.sv @@
// A word accepted on start is latched and raises busy. Busy stays high for the
// compare-and-shift cycle, in which every cell of the row compares its key with
// the query at once; its result is then registered with done high. No new word
// is accepted while busy is high.
// Reset empties the store at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
// ordered_set_successor_engine
// Sorted set of signed keys held in a row of cells, with insert, delete,
// exists, next greater and previous smaller operations (unused op codes act as previous smaller).
// ---------------------------------------------------------------------------
module ordered_set_successor_engine import osse_pkg::*; #(
	parameter int CAPACITY = OSSE_CAPACITY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [OP_W-1:0]         op,
	input  logic signed [KEY_W-1:0] key_in,
	output logic                    done,
	output logic                    hit,
	output logic signed [KEY_W-1:0] value_out,
	output logic                    overflow
);

	logic                    busy_q;
	logic                    done_q;
	logic                    hit_q;
	logic                    ovf_q;
	logic signed [KEY_W-1:0] value_q;
	logic [OP_W-1:0]         op_s1;
	logic signed [KEY_W-1:0] key_s1;

	logic signed [KEY_W-1:0] cell_key [CAPACITY];
	osse_cell_st_t           cell_st  [CAPACITY];
	osse_cmd_t               cmd;

	logic                    present;
	logic                    any_gt;
	logic                    full;
	logic                    res_hit;
	logic                    res_ovf;
	logic signed [KEY_W-1:0] next_key;
	logic signed [KEY_W-1:0] prev_key;
	logic signed [KEY_W-1:0] res_val;

	assign busy      = busy_q;
	assign done      = done_q;
	assign hit       = hit_q;
	assign overflow  = ovf_q;
	assign value_out = value_q;

	assign full = cell_st[CAPACITY-1].occ;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                    l_occ;
		logic                    l_lt;
		logic signed [KEY_W-1:0] l_key;
		logic                    r_occ;
		logic signed [KEY_W-1:0] r_key;

		if (i == 0) begin : g_first
			assign l_occ = 1'b1;
			assign l_lt  = 1'b1;
			assign l_key = '0;
		end else begin : g_inner_l
			assign l_occ = cell_st[i-1].occ;
			assign l_lt  = cell_st[i-1].lt;
			assign l_key = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_occ = 1'b0;
			assign r_key = '0;
		end else begin : g_inner_r
			assign r_occ = cell_st[i+1].occ;
			assign r_key = cell_key[i+1];
		end

		osse_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.query     (key_s1),
			.left_occ  (l_occ),
			.left_lt   (l_lt),
			.left_key  (l_key),
			.right_occ (r_occ),
			.right_key (r_key),
			.key_q     (cell_key[i]),
			.st        (cell_st[i])
		);
	end

	always_comb begin
		logic gt_cur;
		logic gt_prev;
		logic lt_next;
		present  = 1'b0;
		any_gt   = 1'b0;
		next_key = '0;
		prev_key = '0;
		gt_prev  = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			gt_cur  = cell_st[i].occ && !cell_st[i].lt && !cell_st[i].eq;
			lt_next = (i == CAPACITY - 1) ? 1'b0 : cell_st[(i + 1) % CAPACITY].lt;
			present = present | cell_st[i].eq;
			any_gt  = any_gt | gt_cur;
			if (gt_cur && !gt_prev) begin
				next_key = next_key | cell_key[i];
			end
			if (cell_st[i].lt && !lt_next) begin
				prev_key = prev_key | cell_key[i];
			end
			gt_prev = gt_cur;
		end
	end

	always_comb begin
		cmd     = '0;
		res_hit = 1'b0;
		res_ovf = 1'b0;
		res_val = '0;
		unique case (op_s1)
			OP_INSERT: begin
				cmd.ins = busy_q && !present && !full;
				res_hit = !present && !full;
				res_ovf = !present && full;
			end
			OP_DELETE: begin
				cmd.del = busy_q && present;
				res_hit = present;
			end
			OP_EXISTS: begin
				res_hit = present;
			end
			OP_NEXT: begin
				res_hit = any_gt;
				res_val = next_key;
			end
			default: begin
				res_hit = cell_st[0].lt;
				res_val = prev_key;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q;
			if (busy_q) begin
				busy_q <= 1'b0;
			end else if (start) begin
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			op_s1  <= op;
			key_s1 <= key_in;
		end
		if (busy_q) begin
			hit_q   <= res_hit;
			ovf_q   <= res_ovf;
			value_q <= res_val;
		end
	end

endmodule

@@ hdl/osse_checker.sv @@
// ---------------------------------------------------------------------------
// osse_checker
// Port-level checks on the command handshake and result words of the
// ordered set engine.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module osse_checker import osse_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic                    hit,
	input logic                    overflow,
	input logic signed [KEY_W-1:0] value_out
);

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_NEXT(a_busy_done, clk, arst_n, busy, done && !busy)
	`ASSERT_SAME(a_done_after_busy, clk, arst_n, done, $past(busy))
	`ASSERT_SAME(a_ovf_no_hit, clk, arst_n, done && overflow, !hit)
	`ASSERT_SAME(a_value_needs_hit, clk, arst_n, done && (value_out != '0), hit && !overflow)

endmodule

bind ordered_set_successor_engine osse_checker u_osse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.hit       (hit),
	.overflow  (overflow),
	.value_out (value_out)
);

@@ sim/ordered_set_successor_engine_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ordered_set_successor_engine_tb
// Self-checking bench for the ordered set engine. Each accepted word is
// applied to a shadow sorted set kept in the bench, and the hit, value and
// overflow fields of every result strobe are checked against it in order.
// Directed words cover the empty store and the key extremes. Random phases
// then fill the store past capacity, churn it and drain it again, with bursty
// and back-to-back starts.
// ---------------------------------------------------------------------------
module ordered_set_successor_engine_tb;
	import osse_pkg::*;

	localparam int CAP       = OSSE_CAPACITY;
	localparam int POOL_SIZE = 96;

	localparam logic signed [KEY_W-1:0] KEY_LO       = KEY_W'(-1000000000);
	localparam logic signed [KEY_W-1:0] KEY_HI       = KEY_W'(1000000000);
	localparam logic signed [KEY_W-1:0] KEY_FULL_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_FULL_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	typedef struct packed {
		logic                    hit;
		logic signed [KEY_W-1:0] value;
		logic                    overflow;
	} lookup_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [OP_W-1:0]         op = '0;
	logic signed [KEY_W-1:0] key_in = '0;
	logic                    busy;
	logic                    done;
	logic                    hit;
	logic signed [KEY_W-1:0] value_out;
	logic                    overflow;

	logic signed [KEY_W-1:0] shadow_keys [CAP];
	int                      shadow_count = 0;
	lookup_result_t          pending_results [$];
	logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
	int                      error_count = 0;
	int                      burst_left = 0;
	bit                      sender_pacing = 1'b1;

	ordered_set_successor_engine #(
		.CAPACITY(CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.key_in(key_in),
		.done(done),
		.hit(hit),
		.value_out(value_out),
		.overflow(overflow)
	);

	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic lookup_result_t apply_to_shadow_set(logic [OP_W-1:0] code,
			logic signed [KEY_W-1:0] k);
		lookup_result_t r;
		int             pos;
		int             i;
		bit             present;
		r = '0;
		pos = 0;
		while (pos < shadow_count && shadow_keys[pos] < k)
			pos++;
		present = (pos < shadow_count) && (shadow_keys[pos] == k);
		case (code)
			OP_INSERT: begin
				if (!present) begin
					if (shadow_count >= CAP) begin
						r.overflow = 1'b1;
					end else begin
						for (i = shadow_count; i > pos; i--)
							shadow_keys[i] = shadow_keys[i-1];
						shadow_keys[pos] = k;
						shadow_count++;
						r.hit = 1'b1;
					end
				end
			end
			OP_DELETE: begin
				if (present) begin
					for (i = pos; i + 1 < shadow_count; i++)
						shadow_keys[i] = shadow_keys[i+1];
					shadow_count--;
					r.hit = 1'b1;
				end
			end
			OP_EXISTS: begin
				r.hit = present;
			end
			OP_NEXT: begin
				i = present ? pos + 1 : pos;
				if (i < shadow_count) begin
					r.hit = 1'b1;
					r.value = shadow_keys[i];
				end
			end
			default: begin
				if (pos > 0) begin
					r.hit = 1'b1;
					r.value = shadow_keys[pos-1];
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin : check_results
		lookup_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word with none pending", value_out, 0);
			end else begin
				want = pending_results.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", hit, want.hit);
				if (value_out !== want.value)
					report_mismatch("value_out", value_out, want.value);
				if (overflow !== want.overflow)
					report_mismatch("overflow", overflow, want.overflow);
			end
		end
	end

	task automatic pace_sender();
		if (sender_pacing) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(16, 0);
				start <= 1'b0;
				repeat ($urandom_range(7, 1)) @(posedge clk);
			end
		end
	endtask

	task automatic send_word(input logic [OP_W-1:0] code, input logic signed [KEY_W-1:0] k);
		start <= 1'b1;
		op <= code;
		key_in <= k;
		do @(posedge clk); while (busy);
		pending_results.push_back(apply_to_shadow_set(code, k));
		pace_sender();
	endtask

	function automatic logic signed [KEY_W-1:0] random_key(bit full_width);
		if (full_width)
			return KEY_W'($urandom);
		return KEY_W'(int'($urandom_range(2000000000, 0)) - 1000000000);
	endfunction

	task automatic fill_pool(input bit full_width);
		int i;
		for (i = 0; i < POOL_SIZE; i++)
			key_pool[i] = random_key(full_width);
		key_pool[0] = full_width ? KEY_FULL_MIN : KEY_LO;
		key_pool[1] = full_width ? KEY_FULL_MAX : KEY_HI;
		key_pool[2] = '0;
		key_pool[3] = KEY_W'(-1);
	endtask

	function automatic logic signed [KEY_W-1:0] query_key();
		int r;
		r = $urandom_range(99, 0);
		if (r < 50)
			return key_pool[$urandom_range(POOL_SIZE-1, 0)];
		if (r < 65)
			return KEY_W'(key_pool[$urandom_range(POOL_SIZE-1, 0)] + 1);
		if (r < 80)
			return KEY_W'(key_pool[$urandom_range(POOL_SIZE-1, 0)] - 1);
		return random_key(1'($urandom_range(1, 0)));
	endfunction

	task automatic run_random(input int count, input int insert_pct, input int delete_pct);
		int n;
		int r;
		for (n = 0; n < count; n++) begin
			r = $urandom_range(99, 0);
			if (r < insert_pct)
				send_word(OP_INSERT, key_pool[$urandom_range(POOL_SIZE-1, 0)]);
			else if (r < insert_pct + delete_pct)
				send_word(OP_DELETE, query_key());
			else if (r < 96)
				send_word(OP_W'($urandom_range(OP_PREV, OP_EXISTS)), query_key());
			else
				send_word(OP_W'($urandom_range(7, 5)), query_key());
		end
	endtask

	task automatic test_empty_store();
		sender_pacing = 1'b1;
		send_word(OP_EXISTS, '0);
		send_word(OP_NEXT, '0);
		send_word(OP_PREV, '0);
		send_word(OP_DELETE, KEY_W'(5));
	endtask

	task automatic test_extreme_keys();
		send_word(OP_INSERT, KEY_LO);
		send_word(OP_INSERT, KEY_HI);
		send_word(OP_INSERT, '0);
		send_word(OP_INSERT, KEY_FULL_MIN);
		send_word(OP_INSERT, KEY_FULL_MAX);
		send_word(OP_INSERT, '0);
		send_word(OP_EXISTS, KEY_HI);
		send_word(OP_EXISTS, KEY_W'(1));
		send_word(OP_NEXT, KEY_FULL_MIN);
		send_word(OP_NEXT, KEY_FULL_MAX);
		send_word(OP_NEXT, KEY_W'(5));
		send_word(OP_PREV, KEY_FULL_MIN);
		send_word(OP_PREV, '0);
		send_word(OP_W'(5), KEY_W'(1));
		send_word(OP_W'(6), KEY_FULL_MAX);
		send_word(OP_W'(7), KEY_LO);
		send_word(OP_DELETE, '0);
		send_word(OP_DELETE, '0);
		send_word(OP_PREV, KEY_W'(1));
	endtask

	task automatic test_fill_and_overflow();
		fill_pool(1'b0);
		run_random(300, 70, 5);
	endtask

	task automatic test_random_churn();
		run_random(700, 35, 30);
	endtask

	task automatic test_back_to_back();
		sender_pacing = 1'b0;
		run_random(300, 40, 30);
		sender_pacing = 1'b1;
	endtask

	task automatic test_full_width_keys();
		fill_pool(1'b1);
		run_random(250, 60, 10);
	endtask

	task automatic test_drain();
		run_random(250, 5, 70);
	endtask

	task automatic finish_run();
		int waited;
		waited = 0;
		start <= 1'b0;
		while (pending_results.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 0, pending_results.size());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_extreme_keys();
		test_fill_and_overflow();
		test_random_churn();
		test_back_to_back();
		test_full_width_keys();
		test_drain();
		finish_run();
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
